// ----- rtl/jls_pkg.sv -----
// Shared codes, widths and control bundles of the Jacobi solver.
package jls_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = 8;

    // Commands carried on the input tuser
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Result kinds carried on the output tuser
    localparam logic [1:0] ST_READ      = 2'd0;
    localparam logic [1:0] ST_CONVERGED = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd3;

    // Register indexes on the APB port
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_MAXIT = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd;
    } stctl_t;

    typedef struct packed {
        logic clear;
        logic wr;
        logic rd;
    } xctl_t;

endpackage

// ----- rtl/jacobi_linear_solver.sv -----
// Jacobi linear solver: command stream in, result stream out, APB registers.
//
// Input stream: tuser is the command (load A entry, load b entry, solve, read x),
// tdata carries row, col and the 32-bit coefficient. Loads produce no result;
// solve and read each produce one result with the status on tuser and the sweep
// count and x value on tdata.
// A load can be followed directly by the next command. A read registers its x entry
// and moves the result into the output register once that is free; the next command
// is taken only after that. A solve clears x and runs sweeps out of the A/b memory
// and the ping-pong x memory. Each row streams n products through one multiplier,
// then divides by the diagonal in a bit-serial divider. The block takes no command
// while a solve runs.
// The result sits in an output register; while the receiver stalls, commands are
// still taken until a read or solve has a result waiting, which blocks the input.
// Reset restores the registers (n=32, limit 100, tolerance 1) and makes all of x
// read as zero; A and b hold nothing defined until loaded.
module jacobi_linear_solver
    import jls_pkg::*;
#(
    parameter int MAX_SIZE  = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // iterations[7:0], x_value[39:8]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int CW = IW + 1;
    localparam int SW = DATA_W + IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_NUM   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
        begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // Configuration
    logic [5:0]  size_reg;
    logic [7:0]  maxit_reg;
    logic [15:0] tol_reg;
    logic        cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 6'd32;
            maxit_reg <= 8'd100;
            tol_reg   <= 16'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SIZE:  size_reg  <= pwdata[5:0];
                REG_MAXIT: maxit_reg <= pwdata[7:0];
                REG_TOL:   tol_reg   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SIZE:  prdata = 32'(size_reg);
            REG_MAXIT: prdata = 32'(maxit_reg);
            REG_TOL:   prdata = 32'(tol_reg);
            default:   prdata = '0;
        endcase
    end

    logic [CW-1:0] n_act;
    logic [7:0]    limit;

    always_comb
    begin
        if (size_reg == 6'd0)
        begin
            n_act = CW'(1);
        end
        else if (32'(size_reg) > MAX_SIZE)
        begin
            n_act = CW'(MAX_SIZE);
        end
        else
        begin
            n_act = CW'(size_reg);
        end
        limit = (maxit_reg == 8'd0) ? 8'd1 : maxit_reg;
    end

    // Input fields
    logic [1:0]        in_action;
    logic [31:0]       in_row32;
    logic [31:0]       in_col32;
    logic [DATA_W-1:0] in_value;
    logic              row_ok;
    logic              col_ok;
    logic [IW-1:0]     row_idx;
    logic [IW-1:0]     col_idx;
    logic              acc_in;

    assign in_action = s_tuser;
    assign in_row32  = 32'(s_tdata[4:0]);
    assign in_col32  = 32'(s_tdata[9:5]);
    assign in_value  = s_tdata[41:10];
    assign row_ok    = in_row32 < MAX_SIZE;
    assign col_ok    = in_col32 < MAX_SIZE;
    assign row_idx   = in_row32[IW-1:0];
    assign col_idx   = in_col32[IW-1:0];

    // Control state
    logic [2:0]          state_reg;
    logic                cur_reg;
    logic [7:0]          cnt_reg;
    logic [1:0]          status_reg;
    logic                rd_pend_reg;
    logic                rd_ok_reg;
    logic                out_v_reg;
    logic [1:0]          out_st_reg;
    logic [7:0]          out_it_reg;
    logic [DATA_W-1:0]   out_x_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic signed [SW-1:0] last_sum_reg;

    // Datapath
    logic [IW-1:0]        t_reg;
    logic [IW-1:0]        j_reg;
    logic [IW-1:0]        t1_reg;
    logic [DATA_W-1:0]    diag_reg;
    logic signed [63:0]   prod_reg;
    logic signed [63:0]   acc_reg;
    logic signed [SW-1:0] sum_new_reg;
    logic signed [SW:0]   diff_reg;

    assign acc_in   = s_tvalid & s_tready;
    assign s_tready = (state_reg == S_IDLE) && !rd_pend_reg;

    logic out_free;
    assign out_free = !out_v_reg || m_tready;

    // Memories
    stctl_t            st_ctl;
    xctl_t             x_ctl;
    logic [DATA_W-1:0] a_q;
    logic [DATA_W-1:0] b_q;
    logic [DATA_W-1:0] x_q;
    logic [IW:0]       x_raddr;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic              last_t;
    logic              last_j;
    logic              abort;
    logic              solve_go;

    assign last_t   = (CW'(t_reg) + CW'(1)) == n_act;
    assign last_j   = (CW'(j_reg) + CW'(1)) == n_act;
    assign abort    = (state_reg == S_NUM) && (diag_reg == '0);
    assign solve_go = acc_in && (in_action == ACT_SOLVE);

    assign st_ctl.wr_a = acc_in && (in_action == ACT_LOAD_A) && row_ok && col_ok;
    assign st_ctl.wr_b = acc_in && (in_action == ACT_LOAD_B) && row_ok;
    assign st_ctl.rd   = state_reg == S_ROW;

    assign x_ctl.clear = solve_go || abort;
    assign x_ctl.wr    = (state_reg == S_DIV) && div_done;
    assign x_ctl.rd    = (state_reg == S_ROW) || (acc_in && (in_action == ACT_READ));
    assign x_raddr     = (state_reg == S_ROW) ? {cur_reg, t_reg} : {cur_reg, row_idx};

    jls_store #(.IW(IW)) u_store (
        .clk   (clk),
        .ctl   (st_ctl),
        .wrow  (row_idx),
        .wcol  (col_idx),
        .wdata (in_value),
        .rrow  (j_reg),
        .rcol  (t_reg),
        .a_q   (a_q),
        .b_q   (b_q)
    );

    jls_xbank #(.IW(IW)) u_xbank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (x_ctl),
        .waddr ({~cur_reg, j_reg}),
        .wdata (div_q),
        .raddr (x_raddr),
        .rdata (x_q)
    );

    // Numerator b*2^F - sum, saturated to 64 bits
    logic signed [65:0] num_wide;
    logic [63:0]        num_sat;

    always_comb
    begin
        num_wide = (66'(signed'(b_q)) <<< FRAC_BITS) - 66'(acc_reg);
        if ((num_wide[65:63] == 3'b000) || (num_wide[65:63] == 3'b111))
        begin
            num_sat = num_wide[63:0];
        end
        else
        begin
            num_sat = num_wide[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    assign div_start = (state_reg == S_NUM) && !abort;

    jls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_sat),
        .den   (diag_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    logic [SW:0] diff_mag;
    assign diff_mag = diff_reg[SW] ? (~diff_reg + 1'b1) : diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= 1'b0;
            cnt_reg      <= '0;
            status_reg   <= ST_READ;
            rd_pend_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            last_sum_reg <= '0;
        end
        else
        begin
            v1_reg <= state_reg == S_ROW;
            v2_reg <= v1_reg && (t1_reg != j_reg);

            if (out_v_reg && m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            if (rd_pend_reg && out_free)
            begin
                out_v_reg   <= 1'b1;
                out_st_reg  <= ST_READ;
                out_it_reg  <= cnt_reg;
                out_x_reg   <= rd_ok_reg ? x_q : '0;
                rd_pend_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && (in_action == ACT_READ))
                    begin
                        rd_pend_reg <= 1'b1;
                        rd_ok_reg   <= row_ok;
                    end
                    if (solve_go)
                    begin
                        cur_reg      <= 1'b0;
                        cnt_reg      <= '0;
                        last_sum_reg <= '0;
                        state_reg    <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    if (last_t)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    if (abort)
                    begin
                        // zero pivot: leave x cleared and report no sweeps
                        cur_reg      <= 1'b0;
                        cnt_reg      <= '0;
                        last_sum_reg <= '0;
                        status_reg   <= ST_ZERO_DIAG;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= last_j ? S_SWEEP : S_ROW;
                    end
                end
                S_SWEEP:
                begin
                    cnt_reg      <= cnt_reg + 8'd1;
                    last_sum_reg <= sum_new_reg;
                    cur_reg      <= ~cur_reg;
                    state_reg    <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (diff_mag < (SW+1)'(tol_reg))
                    begin
                        status_reg <= ST_CONVERGED;
                        state_reg  <= S_DONE;
                    end
                    else if (cnt_reg >= limit)
                    begin
                        status_reg <= ST_LIMIT;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ROW;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_v_reg  <= 1'b1;
                        out_st_reg <= status_reg;
                        out_it_reg <= cnt_reg;
                        out_x_reg  <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Sweep datapath: counters, multiply stage, accumulate stage
    always_ff @(posedge clk)
    begin
        t1_reg <= t_reg;
        if (v1_reg)
        begin
            if (t1_reg == j_reg)
            begin
                diag_reg <= a_q;
            end
            prod_reg <= signed'(a_q) * signed'(x_q);
        end
        if (v2_reg)
        begin
            acc_reg <= sat_add(acc_reg, prod_reg);
        end

        if (solve_go || ((state_reg == S_CHECK) && (state_reg != S_IDLE)))
        begin
            t_reg       <= '0;
            j_reg       <= '0;
            acc_reg     <= '0;
            sum_new_reg <= '0;
        end
        else if (state_reg == S_ROW)
        begin
            t_reg <= last_t ? '0 : t_reg + 1'b1;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            acc_reg     <= '0;
            sum_new_reg <= sum_new_reg + SW'(signed'(div_q));
            if (!last_j)
            begin
                j_reg <= j_reg + 1'b1;
            end
        end

        if (state_reg == S_SWEEP)
        begin
            diff_reg <= (SW+1)'(last_sum_reg) - (SW+1)'(sum_new_reg);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {out_x_reg, out_it_reg};

`ifndef SYNTHESIS
    // New x entries are written only on divide completion, with no read pending
    assert property (@(posedge clk) disable iff (!rst_n)
        x_ctl.wr |-> (state_reg == S_DIV) && !rd_pend_reg)
        else $error("x write outside divide completion");

    // Divider results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done while not waiting");

    // A zero-pivot result always reports no sweeps
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (out_st_reg == ST_ZERO_DIAG)) |-> (out_it_reg == 8'd0))
        else $error("zero diagonal result with nonzero sweep count");
`endif

endmodule

// ----- rtl/jls_store.sv -----
// Coefficient memory for matrix A and right-hand side b.
module jls_store
    import jls_pkg::*;
#(
    parameter int IW = 5
)
(
    input  logic              clk,
    input  stctl_t            ctl,
    input  logic [IW-1:0]     wrow,
    input  logic [IW-1:0]     wcol,
    input  logic [DATA_W-1:0] wdata,
    input  logic [IW-1:0]     rrow,
    input  logic [IW-1:0]     rcol,
    output logic [DATA_W-1:0] a_q,
    output logic [DATA_W-1:0] b_q
);

    logic [DATA_W-1:0] a_mem [0:(1 << (2*IW))-1];
    logic [DATA_W-1:0] b_mem [0:(1 << IW)-1];
    logic [DATA_W-1:0] a_q_reg;
    logic [DATA_W-1:0] b_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_a)
        begin
            a_mem[{wrow, wcol}] <= wdata;
        end
        if (ctl.wr_b)
        begin
            b_mem[wrow] <= wdata;
        end
        if (ctl.rd)
        begin
            a_q_reg <= a_mem[{rrow, rcol}];
            b_q_reg <= b_mem[rrow];
        end
    end

    assign a_q = a_q_reg;
    assign b_q = b_q_reg;

endmodule

// ----- rtl/jls_xbank.sv -----
// Ping-pong memory for the old and new solution vectors, with per-entry valid bits.
module jls_xbank
    import jls_pkg::*;
#(
    parameter int IW = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  xctl_t             ctl,
    input  logic [IW:0]       waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [IW:0]       raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 << IW;

    logic [DATA_W-1:0] x_mem [0:DEPTH-1];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            x_mem[waddr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= x_mem[raddr];
        end
    end

    // Unwritten entries read as zero
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ----- rtl/jls_div.sv -----
// Bit-serial signed divider, 64-bit dividend by 32-bit divisor, saturated 32-bit quotient.
module jls_div
    import jls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [DATA_W-1:0] quot
);

    logic        load_reg;
    logic        run_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [31:0] rem_reg;
    logic        neg_reg;
    logic [31:0] quot_reg;
    logic [32:0] shifted;
    logic        ge;
    logic [32:0] diff;

    assign shifted = {rem_reg, dvd_reg[63]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                load_reg <= 1'b1;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                run_reg  <= 1'b1;
            end
            else if (run_reg && (cnt_reg == 6'd63))
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num;
            dsr_reg <= den;
        end
        else if (load_reg)
        begin
            // Take magnitudes, remember the quotient sign
            dvd_reg <= dvd_reg[63] ? (~dvd_reg + 64'd1) : dvd_reg;
            dsr_reg <= dsr_reg[31] ? (~dsr_reg + 32'd1) : dsr_reg;
            neg_reg <= dvd_reg[63] ^ dsr_reg[31];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            dvd_reg <= {dvd_reg[62:0], ge};
            cnt_reg <= cnt_reg + 6'd1;
        end
        else if (fin_reg)
        begin
            if (!neg_reg)
            begin
                quot_reg <= (|dvd_reg[63:31]) ? 32'h7FFF_FFFF : dvd_reg[31:0];
            end
            else if ((|dvd_reg[63:32]) || (dvd_reg[31] && (|dvd_reg[30:0])))
            begin
                quot_reg <= 32'h8000_0000;
            end
            else
            begin
                quot_reg <= ~dvd_reg[31:0] + 32'd1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the Jacobi solver: command stream, APB setup, result check.
`timescale 1ns / 100ps

module tb_top;
    import jls_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  it;
        logic [31:0] xv;
    } sol_result_t;

    typedef struct {
        logic [1:0]  act;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] val;
        bit          typed;
        logic [1:0]  st;
        logic [7:0]  it;
        logic [31:0] xv;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // row[4:0], col[9:5], value[41:10], zero pad
    logic [1:0]  s_tuser = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // iterations[7:0], x_value[39:8]
    logic [1:0]  m_tuser;        // status[1:0]

    jacobi_linear_solver uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // Solver mirror
    logic signed [31:0] a_mem [32][32];
    logic signed [31:0] b_mem [32];
    logic signed [31:0] x_cur [32];
    bit                 a_written [32][32];
    bit                 b_written [32];
    logic [7:0]         sweeps;
    logic [5:0]         size_reg;
    logic [7:0]         maxit_reg;
    logic [15:0]        tol_reg;

    sol_result_t expected_results [$];
    int  errors = 0;
    int  items_sent = 0;
    bit  burst = 0;
    bit  long_hold_req = 0;
    int  idle_cycles = 0;

    function automatic longint sat_add(longint a, longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    function automatic int active_n();
        if (size_reg == 0)
            return 1;
        if (size_reg > 32)
            return 32;
        return size_reg;
    endfunction

    function automatic longint sum_x(int n);
        longint s;
        s = 0;
        for (int i = 0; i < n; i++)
            s += longint'(x_cur[i]);
        return s;
    endfunction

    function automatic logic [1:0] run_jacobi();
        int n;
        int lim;
        longint before_sum, after_sum, acc, num, d, q, diff;
        logic signed [31:0] xn [32];
        n = active_n();
        lim = (maxit_reg == 0) ? 1 : maxit_reg;
        for (int i = 0; i < 32; i++)
        begin
            x_cur[i] = '0;
            xn[i] = '0;
        end
        sweeps = 0;
        for (int j = 0; j < n; j++)
            if (a_mem[j][j] == 0)
                return ST_ZERO_DIAG;
        while (sweeps < lim)
        begin
            before_sum = sum_x(n);
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int t = 0; t < n; t++)
                    if (t != j)
                        acc = sat_add(acc, longint'(a_mem[j][t]) * longint'(x_cur[t]));
                num = longint'(b_mem[j]) * 65536;
                if (acc == 64'sh8000_0000_0000_0000)
                    num = sat_add(sat_add(num, 64'sh7FFF_FFFF_FFFF_FFFF), 1);
                else
                    num = sat_add(num, -acc);
                d = longint'(a_mem[j][j]);
                if (d == -1)
                    q = (num == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF : -num;
                else
                    q = num / d;
                if (q > 64'sh7FFF_FFFF)
                    q = 64'sh7FFF_FFFF;
                if (q < -64'sh8000_0000)
                    q = -64'sh8000_0000;
                xn[j] = q[31:0];
            end
            for (int i = 0; i < 32; i++)
                x_cur[i] = xn[i];
            sweeps++;
            after_sum = sum_x(n);
            diff = before_sum - after_sum;
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(tol_reg))
                return ST_CONVERGED;
        end
        return ST_LIMIT;
    endfunction

    task automatic apply_command(logic [1:0] act, logic [4:0] row, logic [4:0] col,
                                 logic [31:0] val);
        sol_result_t r;
        case (act)
            ACT_LOAD_A:
            begin
                a_mem[row][col] = val;
                a_written[row][col] = 1;
            end
            ACT_LOAD_B:
            begin
                b_mem[row] = val;
                b_written[row] = 1;
            end
            ACT_SOLVE:
            begin
                r.st = run_jacobi();
                r.it = sweeps;
                r.xv = '0;
                expected_results.push_back(r);
            end
            default:
            begin
                r.st = ST_READ;
                r.it = sweeps;
                r.xv = x_cur[row];
                expected_results.push_back(r);
            end
        endcase
    endtask

    task automatic send_cmd(logic [1:0] act, logic [4:0] row, logic [4:0] col,
                            logic [31:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, val, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        apply_command(act, row, col, val);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        // drop the last command, then drain the block before touching its registers
        @(negedge clk) s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        s_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE:  size_reg  = val[5:0];
            REG_MAXIT: maxit_reg = val[7:0];
            default:   tol_reg   = val[15:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] n, logic [31:0] it, logic [31:0] tol);
        write_reg(REG_SIZE, n);
        write_reg(REG_MAXIT, it);
        write_reg(REG_TOL, tol);
    endtask

    function automatic logic [31:0] coeff(int j, int t, int n);
        logic [31:0] v;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        if (j == t)
        begin
            v = n * 16 + $urandom_range(1, 200);
            return $urandom_range(0, 1) ? -v : v;
        end
        return $urandom_range(0, 16) - 8;
    endfunction

    task automatic fill_missing(int n);
        for (int j = 0; j < n; j++)
        begin
            for (int t = 0; t < n; t++)
                if (!a_written[j][t])
                    send_cmd(ACT_LOAD_A, j, t, coeff(j, t, n));
            if (!b_written[j])
                send_cmd(ACT_LOAD_B, j, 0, $urandom_range(0, 100000) - 50000);
        end
    endtask

    // one well-formed system: full load, solve, a few reads
    task automatic send_system(int n);
        int reads;
        for (int j = 0; j < n; j++)
            for (int t = 0; t < n; t++)
                send_cmd(ACT_LOAD_A, j, t, coeff(j, t, n));
        for (int j = 0; j < n; j++)
            send_cmd(ACT_LOAD_B, j, $urandom_range(0, 31),
                     $urandom_range(0, 7) == 0 ? $urandom
                                               : $urandom_range(0, 100000) - 50000);
        send_cmd(ACT_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        reads = $urandom_range(1, 3);
        repeat (reads)
            send_cmd(ACT_READ, $urandom_range(0, n - 1), $urandom_range(0, 31), $urandom);
    endtask

    task automatic run_phase(int quota);
        int r;
        int n;
        int stop;
        n = active_n();
        stop = items_sent + quota;
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 9);
            burst = ($urandom_range(0, 4) == 0);
            if (r < 6)
                send_system(n);
            else if (r < 8)
                send_cmd($urandom_range(0, 1) ? ACT_LOAD_A : ACT_LOAD_B,
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            else if (r == 8)
                send_cmd(ACT_READ, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            else
            begin
                fill_missing(n);
                send_cmd(ACT_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            end
        end
        burst = 0;
    endtask

    dir_row_t dir_tbl [21] = '{
        '{ACT_READ,   0,  0, 32'h0,        1, ST_READ,      8'd0, 32'h0},
        '{ACT_READ,   31, 31, 32'hFFFFFFFF, 1, ST_READ,     8'd0, 32'h0},
        '{ACT_LOAD_A, 0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_B, 0,  0, 32'd5,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_SOLVE,  0,  0, 32'h0,        1, ST_ZERO_DIAG, 8'd0, 32'h0},
        '{ACT_READ,   0,  0, 32'h0,        1, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_A, 0,  0, 32'd1,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_SOLVE,  0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_READ,   0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_A, 0,  0, 32'hFFFFFFFF, 0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_B, 0,  0, 32'h80000000, 0, ST_READ,      8'd0, 32'h0},
        '{ACT_SOLVE,  0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_READ,   0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_A, 31, 31, 32'h7FFFFFFF, 0, ST_READ,     8'd0, 32'h0},
        '{ACT_LOAD_A, 0,  31, 32'h80000000, 0, ST_READ,     8'd0, 32'h0},
        '{ACT_LOAD_B, 31, 0, 32'h7FFFFFFF, 0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_A, 0,  0, 32'h7FFFFFFF, 0, ST_READ,      8'd0, 32'h0},
        '{ACT_LOAD_B, 0,  0, 32'h7FFFFFFF, 0, ST_READ,      8'd0, 32'h0},
        '{ACT_SOLVE,  0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_READ,   0,  0, 32'h0,        0, ST_READ,      8'd0, 32'h0},
        '{ACT_READ,   31, 0, 32'h0,        0, ST_READ,      8'd0, 32'h0}
    };

    initial
    begin
        sol_result_t typed_res;
        for (int i = 0; i < 32; i++)
            x_cur[i] = '0;
        sweeps = 0;
        size_reg = 6'd32;
        maxit_reg = 8'd100;
        tol_reg = 16'd1;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // read-after-reset rows come first, before any register change
        for (int i = 0; i < 2; i++)
        begin
            send_cmd(dir_tbl[i].act, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].val);
            typed_res = '{dir_tbl[i].st, dir_tbl[i].it, dir_tbl[i].xv};
            void'(expected_results.pop_back());
            expected_results.push_back(typed_res);
        end
        set_config(1, 3, 1);
        for (int i = 2; i < 21; i++)
        begin
            send_cmd(dir_tbl[i].act, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].val);
            if (dir_tbl[i].typed)
            begin
                typed_res = '{dir_tbl[i].st, dir_tbl[i].it, dir_tbl[i].xv};
                void'(expected_results.pop_back());
                expected_results.push_back(typed_res);
            end
        end

        set_config(3, 100, 1);
        run_phase(60);
        // hold the receiver while reads pile up behind the output register
        long_hold_req = 1;
        burst = 1;
        repeat (12)
            send_cmd(ACT_READ, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        burst = 0;
        run_phase(40);
        set_config(1, 255, 0);
        run_phase(40);
        set_config(4, 20, 65535);
        run_phase(120);
        set_config(0, 0, 1000);
        run_phase(100);
        set_config(2, 50, 16);
        run_phase(120);
        set_config(5, 30, 4);
        run_phase(120);
        set_config(40, 2, 1);
        fill_missing(32);
        send_cmd(ACT_SOLVE, 0, 0, 32'h0);
        repeat (4)
            send_cmd(ACT_READ, $urandom_range(0, 31), 0, $urandom);
        set_config(32, 1, 200);
        send_cmd(ACT_SOLVE, 0, 0, 32'h0);
        send_cmd(ACT_READ, 31, 0, 32'h0);

        @(negedge clk) s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: random stalls, occasional long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (long_hold_req)
            begin
                gap = 400;
                long_hold_req = 0;
            end
            repeat (gap) @(negedge clk) m_tready <= 1'b0;
            @(negedge clk) m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        sol_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d", m_tuser);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== exp_r.it)
                begin
                    $error("iterations: expected %0d, got %0d", exp_r.it, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[39:8] !== exp_r.xv)
                begin
                    $error("x_value: expected %0d, got %0d",
                           $signed(exp_r.xv), $signed(m_tdata[39:8]));
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
